// ----- hw/rtl/dncc_pkg.sv -----
package dncc_pkg;

	localparam logic [1:0] KIND_ENCODE = 2'd0;
	localparam logic [1:0] KIND_DECODE = 2'd1;
	localparam logic [1:0] KIND_RECODE = 2'd2;

	localparam logic [15:0] GROUP_DAYS = 16'd1461;
	localparam logic [15:0] LEAP_DAYS  = 16'd366;
	localparam logic [15:0] YEAR_DAYS  = 16'd365;
	localparam logic [3:0]  LAST_MONTH = 4'd12;
	localparam logic [3:0]  FIRST_MONTH = 4'd1;
	localparam logic [7:0]  MAX_YEAR   = 8'd99;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic grp_step;
		logic yfirst_step;
		logic yrest_step;
		logic mon_step;
		logic dec_end;
		logic enc_base;
		logic enc_step;
		logic finish;
	} dncc_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic gt_group;
		logic gt_leap;
		logic gt_year;
		logic mon_more;
		logic enc_more;
	} dncc_stat_t;

	// Length of a month; zero for codes outside one to twelve
	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
		logic [4:0] len;
		case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// (n + 4) mod 7 + 1, by folding octal digits (8 is 1 mod 7)
	function automatic logic [2:0] weekday_of(input logic [15:0] n);
		logic [16:0] v;
		logic [5:0]  s1;
		logic [3:0]  s2;
		logic [3:0]  r;
		v  = 17'(n) + 17'd4;
		s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12])
			+ 6'(v[16:15]);
		s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
		r  = (s2 >= 4'd7) ? (s2 - 4'd7) : s2;
		return 3'(r + 4'd1);
	endfunction

endpackage

// ----- hw/rtl/dncc_cmd_if.sv -----
interface dncc_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] day_number;
	logic [6:0]  year_in;
	logic [3:0]  month_in;
	logic [4:0]  day_in;
	logic        set_year;
	logic        set_month;
	logic        set_day;

	modport source (output valid, kind, day_number, year_in, month_in, day_in,
		set_year, set_month, set_day, input ready);
	modport sink (input valid, kind, day_number, year_in, month_in, day_in,
		set_year, set_month, set_day, output ready);
endinterface

// ----- hw/rtl/dncc_res_if.sv -----
interface dncc_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] day_number_out;
	logic [6:0]  year_out;
	logic [3:0]  month_out;
	logic [4:0]  day_out;
	logic [2:0]  weekday;
	logic        leap;
	logic        valid_res;

	modport source (output valid, day_number_out, year_out, month_out, day_out,
		weekday, leap, valid_res, input ready);
	modport sink (input valid, day_number_out, year_out, month_out, day_out,
		weekday, leap, valid_res, output ready);
endinterface

// ----- hw/rtl/day_number_calendar_converter.sv -----
// Day number / calendar date converter for two-digit years, where every year
// divisible by four (year 0 included) is a leap year. Each item on cmd is an
// encode (kind 0: date to day number), a decode (kind 1, and the unused code
// 3: day number to date) or a recode (kind 2: decode, replace the fields whose
// set_* bit is high, encode again); each gives exactly one item on res, with
// weekday, leap and a validity flag. Fields are never rejected, only flagged.
// The block works on one item at a time. An encode sums the lengths of the
// months before the given one; a decode strips about day_number/1461
// four-year groups, then up to 3 years and up to 11 months; a recode adds an
// encode to its decode. The block returns to idle before the next item is
// taken. The work is done by the shared subtractor that strips four-year
// groups, years and months one per cycle, and by the adder that sums month
// lengths. A finished result waits in the output register while the next
// item is already being taken in.
module day_number_calendar_converter
	import dncc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	dncc_cmd_if.sink   cmd,
	dncc_res_if.source res
);

	dncc_cmd_t  ctl_cmd;
	dncc_stat_t dp_stat;

	// Sequence the item: group strip, year strip, month strip, encode
	dncc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.in_kind   (cmd.kind),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.stat      (dp_stat),
		.cmd       (ctl_cmd)
	);

	// Hold the working day count, the date fields and the result register
	dncc_dp u_dp (
		.clk            (clk),
		.cmd            (ctl_cmd),
		.stat           (dp_stat),
		.kind           (cmd.kind),
		.day_number     (cmd.day_number),
		.year_in        (cmd.year_in),
		.month_in       (cmd.month_in),
		.day_in         (cmd.day_in),
		.set_year       (cmd.set_year),
		.set_month      (cmd.set_month),
		.set_day        (cmd.set_day),
		.day_number_out (res.day_number_out),
		.year_out       (res.year_out),
		.month_out      (res.month_out),
		.day_out        (res.day_out),
		.weekday        (res.weekday),
		.leap           (res.leap),
		.valid_res      (res.valid_res)
	);

endmodule

// ----- hw/rtl/dncc_ctrl.sv -----
module dncc_ctrl
	import dncc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] in_kind,
	output logic       out_valid,
	input  logic       out_ready,
	input  dncc_stat_t stat,
	output dncc_cmd_t  cmd
);

	typedef enum logic [2:0] {
		IDLE, GROUP, YFIRST, YREST, MONTH, ENC_BASE, ENC_MONTH, DONE
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   recode_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = (in_kind == KIND_ENCODE) ? ENC_BASE : GROUP;
				end
			end
			GROUP: begin
				if (stat.gt_group) cmd.grp_step = 1'b1;
				else state_nx = YFIRST;
			end
			YFIRST: begin
				cmd.yfirst_step = stat.gt_leap;
				state_nx = stat.gt_leap ? YREST : MONTH;
			end
			YREST: begin
				if (stat.gt_year) cmd.yrest_step = 1'b1;
				else state_nx = MONTH;
			end
			MONTH: begin
				if (stat.mon_more) begin
					cmd.mon_step = 1'b1;
				end else begin
					cmd.dec_end = 1'b1;
					state_nx = recode_q ? ENC_BASE : DONE;
				end
			end
			ENC_BASE: begin
				cmd.enc_base = 1'b1;
				state_nx = ENC_MONTH;
			end
			ENC_MONTH: begin
				if (stat.enc_more) cmd.enc_step = 1'b1;
				else state_nx = DONE;
			end
			DONE: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_nx = IDLE;
				end
			end
			default: state_nx = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			recode_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load) recode_q <= (in_kind == KIND_RECODE);
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- hw/rtl/dncc_dp.sv -----
module dncc_dp
	import dncc_pkg::*;
(
	input  logic        clk,
	input  dncc_cmd_t   cmd,
	output dncc_stat_t  stat,
	input  logic [1:0]  kind,
	input  logic [15:0] day_number,
	input  logic [6:0]  year_in,
	input  logic [3:0]  month_in,
	input  logic [4:0]  day_in,
	input  logic        set_year,
	input  logic        set_month,
	input  logic        set_day,
	output logic [15:0] day_number_out,
	output logic [6:0]  year_out,
	output logic [3:0]  month_out,
	output logic [4:0]  day_out,
	output logic [2:0]  weekday,
	output logic        leap,
	output logic        valid_res
);

	logic [15:0] num_q;
	logic [15:0] work_q;
	logic [7:0]  year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [3:0]  mcnt_q;
	logic        decode_q;
	logic [6:0]  yin_q;
	logic [3:0]  min_q;
	logic [4:0]  din_q;
	logic        sety_q;
	logic        setm_q;
	logic        setd_q;

	logic [15:0] res_num_q;
	logic [6:0]  res_year_q;
	logic [3:0]  res_month_q;
	logic [4:0]  res_day_q;
	logic [2:0]  res_wday_q;
	logic        res_leap_q;
	logic        res_valid_q;

	logic        year_leap;
	logic [4:0]  cur_len;
	logic [4:0]  cnt_len;
	logic [16:0] year_prod;
	logic [6:0]  year_quarter;
	logic [15:0] enc_base;
	logic [15:0] fin_num;
	logic        fin_valid;

	assign year_leap    = (year_q[1:0] == 2'b00);
	assign cur_len      = month_len(year_leap, month_q);
	assign cnt_len      = month_len(year_leap, mcnt_q);
	assign year_prod    = 17'(year_q) * 17'(YEAR_DAYS);
	assign year_quarter = 7'((9'(year_q) + 9'd3) >> 2);
	assign enc_base     = year_prod[15:0] + 16'(year_quarter) + 16'(day_q);
	assign fin_num      = decode_q ? num_q : work_q;
	assign fin_valid    = (year_q <= MAX_YEAR) && (month_q >= FIRST_MONTH)
		&& (month_q <= LAST_MONTH) && (day_q != 5'd0) && (day_q <= cur_len);

	assign stat.gt_group = (work_q > GROUP_DAYS);
	assign stat.gt_leap  = (work_q > LEAP_DAYS);
	assign stat.gt_year  = (work_q > YEAR_DAYS);
	assign stat.mon_more = (month_q < LAST_MONTH) && (work_q > 16'(cur_len));
	assign stat.enc_more = (mcnt_q < month_q) && (mcnt_q <= LAST_MONTH);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q    <= day_number;
			work_q   <= day_number;
			decode_q <= (kind != KIND_ENCODE) && (kind != KIND_RECODE);
			yin_q    <= year_in;
			min_q    <= month_in;
			din_q    <= day_in;
			sety_q   <= set_year;
			setm_q   <= set_month;
			setd_q   <= set_day;
			if (kind == KIND_ENCODE) begin
				year_q  <= {1'b0, year_in};
				month_q <= month_in;
				day_q   <= day_in;
			end else begin
				year_q  <= 8'd0;
				month_q <= FIRST_MONTH;
			end
		end
		if (cmd.grp_step) begin
			work_q <= work_q - GROUP_DAYS;
			year_q <= year_q + 8'd4;
		end
		if (cmd.yfirst_step) begin
			work_q <= work_q - LEAP_DAYS;
			year_q <= year_q + 8'd1;
		end
		if (cmd.yrest_step) begin
			work_q <= work_q - YEAR_DAYS;
			year_q <= year_q + 8'd1;
		end
		if (cmd.mon_step) begin
			work_q  <= work_q - 16'(cur_len);
			month_q <= month_q + 4'd1;
		end
		if (cmd.dec_end) begin
			// Overrides apply only to recode; plain decode keeps what it found
			day_q <= (!decode_q && setd_q) ? din_q : work_q[4:0];
			if (!decode_q && sety_q) year_q <= {1'b0, yin_q};
			if (!decode_q && setm_q) month_q <= min_q;
		end
		if (cmd.enc_base) begin
			work_q <= enc_base;
			mcnt_q <= FIRST_MONTH;
		end
		if (cmd.enc_step) begin
			work_q <= work_q + 16'(cnt_len);
			mcnt_q <= mcnt_q + 4'd1;
		end
		if (cmd.finish) begin
			res_num_q   <= fin_num;
			res_year_q  <= year_q[6:0];
			res_month_q <= month_q;
			res_day_q   <= day_q;
			res_wday_q  <= weekday_of(fin_num);
			res_leap_q  <= year_leap;
			res_valid_q <= fin_valid;
		end
	end

	assign day_number_out = res_num_q;
	assign year_out       = res_year_q;
	assign month_out      = res_month_q;
	assign day_out        = res_day_q;
	assign weekday        = res_wday_q;
	assign leap           = res_leap_q;
	assign valid_res      = res_valid_q;

endmodule
